>>> hw/rtl/boc_pkg.sv
// ----------------------------------------------------------------------------
// boc_pkg
// Shared constants, register indexes and corner selection table for the
// oriented box corner generator.
// ----------------------------------------------------------------------------
`default_nettype none
package boc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_ROT_W   = 3'd0;
	localparam logic [2:0] REG_ROT_X   = 3'd1;
	localparam logic [2:0] REG_ROT_Y   = 3'd2;
	localparam logic [2:0] REG_ROT_Z   = 3'd3;
	localparam logic [2:0] REG_SCALE_X = 3'd4;
	localparam logic [2:0] REG_SCALE_Y = 3'd5;
	localparam logic [2:0] REG_SCALE_Z = 3'd6;

	localparam int NUM_CORNERS = 8;
	localparam logic [2:0] LAST_CORNER = 3'd7;

	// which axes take the max coordinate, bit a for axis a
	function automatic logic [2:0] corner_sel(input logic [2:0] k);
		logic [2:0] s;
		case (k)
			3'd0: s = 3'b000;
			3'd1: s = 3'b001;
			3'd2: s = 3'b010;
			3'd3: s = 3'b100;
			3'd4: s = 3'b111;
			3'd5: s = 3'b110;
			3'd6: s = 3'b101;
			3'd7: s = 3'b011;
			default: s = 3'b000;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/box_to_oriented_corners.sv
// Each corner slot enters the corner pipeline and passes through stages 1 to 6;
// corner 0 of a box leaves first, the rest follow in index order, one per cycle.
// The box rate is set by the single result port (one corner per cycle); busy
// stays high while the earlier corners of a box are issued and drops while
// corner 7 is issued, so the next box follows with no gap.
// Reset clears valid bits, the corner sequencer and loads the register defaults.
// The receiver cannot stall: each corner is shown for one cycle with out_valid.
// ----------------------------------------------------------------------------
// box_to_oriented_corners
// Rotation basis from a quaternion, per-axis scaling and eight corner words
// produced through a six-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module box_to_oriented_corners (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] min_x,
	input  wire logic signed [31:0] min_y,
	input  wire logic signed [31:0] min_z,
	input  wire logic signed [31:0] max_x,
	input  wire logic signed [31:0] max_y,
	input  wire logic signed [31:0] max_z,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    out_valid,
	output logic [2:0]              corner_index,
	output logic signed [31:0]      corner_x,
	output logic signed [31:0]      corner_y,
	output logic signed [31:0]      corner_z,
	output logic                    is_last
);

	// configuration registers
	logic signed [15:0] rot_q [4];
	logic signed [15:0] scale_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 16'sd16384;
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			rot_q[3] <= '0;
			scale_q[0] <= 16'sd256;
			scale_q[1] <= 16'sd256;
			scale_q[2] <= 16'sd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				boc_pkg::REG_ROT_W:   rot_q[0] <= cfg_data;
				boc_pkg::REG_ROT_X:   rot_q[1] <= cfg_data;
				boc_pkg::REG_ROT_Y:   rot_q[2] <= cfg_data;
				boc_pkg::REG_ROT_Z:   rot_q[3] <= cfg_data;
				boc_pkg::REG_SCALE_X: scale_q[0] <= cfg_data;
				boc_pkg::REG_SCALE_Y: scale_q[1] <= cfg_data;
				boc_pkg::REG_SCALE_Z: scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// rotation basis, from configuration only: products, then sums and rounding
	logic signed [31:0] pr_q [10];
	logic signed [19:0] ax_q [3][3];
	logic signed [34:0] raw [3][3];

	always_ff @(posedge clk) begin
		pr_q[0] <= rot_q[0] * rot_q[0];
		pr_q[1] <= rot_q[1] * rot_q[1];
		pr_q[2] <= rot_q[2] * rot_q[2];
		pr_q[3] <= rot_q[3] * rot_q[3];
		pr_q[4] <= rot_q[1] * rot_q[2];
		pr_q[5] <= rot_q[0] * rot_q[3];
		pr_q[6] <= rot_q[1] * rot_q[3];
		pr_q[7] <= rot_q[0] * rot_q[2];
		pr_q[8] <= rot_q[2] * rot_q[3];
		pr_q[9] <= rot_q[0] * rot_q[1];
	end

	always_comb begin
		raw[0][0] = 35'(pr_q[0]) + 35'(pr_q[1]) - 35'(pr_q[2]) - 35'(pr_q[3]);
		raw[1][1] = 35'(pr_q[0]) - 35'(pr_q[1]) + 35'(pr_q[2]) - 35'(pr_q[3]);
		raw[2][2] = 35'(pr_q[0]) - 35'(pr_q[1]) - 35'(pr_q[2]) + 35'(pr_q[3]);
		raw[0][1] = (35'(pr_q[4]) + 35'(pr_q[5])) <<< 1;
		raw[0][2] = (35'(pr_q[6]) - 35'(pr_q[7])) <<< 1;
		raw[1][0] = (35'(pr_q[4]) - 35'(pr_q[5])) <<< 1;
		raw[1][2] = (35'(pr_q[8]) + 35'(pr_q[9])) <<< 1;
		raw[2][0] = (35'(pr_q[6]) + 35'(pr_q[7])) <<< 1;
		raw[2][1] = (35'(pr_q[8]) - 35'(pr_q[9])) <<< 1;
	end

	// off-diagonal entries reach +-2^18 for a non-unit quaternion
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			for (int j = 0; j < 3; j++) begin
				ax_q[a][j] <= 20'((raw[a][j] + 35'sd8192) >>> 14);
			end
		end
	end

	// box capture and corner sequencer
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic signed [31:0] pos_q [3];
	logic [2:0]         cnt_q;
	logic               run_q;

	// free again while the last corner is issued
	assign busy = run_q && (cnt_q != boc_pkg::LAST_CORNER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start && !busy) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == boc_pkg::LAST_CORNER) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			lo_q[0] <= min_x; lo_q[1] <= min_y; lo_q[2] <= min_z;
			hi_q[0] <= max_x; hi_q[1] <= max_y; hi_q[2] <= max_z;
			pos_q[0] <= pos_x; pos_q[1] <= pos_y; pos_q[2] <= pos_z;
		end
	end

	// stage 1: pick min or max per axis
	logic               v_s1;
	logic [2:0]         k_s1;
	logic signed [31:0] c_s1 [3];
	logic signed [31:0] p_s1 [3];
	logic [2:0]         sel;

	assign sel = boc_pkg::corner_sel(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= run_q;
	end

	always_ff @(posedge clk) begin
		k_s1 <= cnt_q;
		for (int a = 0; a < 3; a++) begin
			c_s1[a] <= sel[a] ? hi_q[a] : lo_q[a];
			p_s1[a] <= pos_q[a];
		end
	end

	// stage 2: coordinate times scale
	logic               v_s2;
	logic [2:0]         k_s2;
	logic signed [47:0] m_s2 [3];
	logic signed [31:0] p_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		k_s2 <= k_s1;
		for (int a = 0; a < 3; a++) begin
			m_s2[a] <= c_s1[a] * scale_q[a];
			p_s2[a] <= p_s1[a];
		end
	end

	// stage 3: round scaled coordinate to Q24.16
	logic               v_s3;
	logic [2:0]         k_s3;
	logic signed [39:0] s_s3 [3];
	logic signed [31:0] p_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		k_s3 <= k_s2;
		for (int a = 0; a < 3; a++) begin
			s_s3[a] <= 40'((m_s2[a] + 48'sd128) >>> 8);
			p_s3[a] <= p_s2[a];
		end
	end

	// stage 4: axis entry products, split at bit 20 of the coordinate
	logic               v_s4;
	logic [2:0]         k_s4;
	logic signed [38:0] ph_s4 [3][3];
	logic signed [38:0] pl_s4 [3][3];
	logic signed [31:0] p_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	// upper part is signed, lower part is a plain magnitude
	always_ff @(posedge clk) begin
		k_s4 <= k_s3;
		for (int a = 0; a < 3; a++) begin
			p_s4[a] <= p_s3[a];
			for (int j = 0; j < 3; j++) begin
				ph_s4[a][j] <= 39'($signed(s_s3[a][39:20])) * 39'(ax_q[a][j]);
				pl_s4[a][j] <= 39'($signed({1'b0, s_s3[a][19:0]})) * 39'(ax_q[a][j]);
			end
		end
	end

	// stage 5: sum of products, round by 14
	logic               v_s5;
	logic [2:0]         k_s5;
	logic signed [45:0] r_s5 [3];
	logic signed [31:0] p_s5 [3];
	logic signed [60:0] acc [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = ((61'(ph_s4[0][j]) + 61'(ph_s4[1][j]) + 61'(ph_s4[2][j])) <<< 20)
				+ 61'(pl_s4[0][j]) + 61'(pl_s4[1][j]) + 61'(pl_s4[2][j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		k_s5 <= k_s4;
		for (int j = 0; j < 3; j++) begin
			r_s5[j] <= 46'((acc[j] + 61'sd8192) >>> 14);
			p_s5[j] <= p_s4[j];
		end
	end

	// stage 6: add position and saturate
	logic signed [46:0] sum [3];
	logic signed [31:0] o_s6 [3];
	logic               v_s6;
	logic [2:0]         k_s6;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum[j] = 47'(r_s5[j]) + 47'(p_s5[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		k_s6 <= k_s5;
		for (int j = 0; j < 3; j++) begin
			if (sum[j] > 47'sd2147483647)       o_s6[j] <= 32'sh7fffffff;
			else if (sum[j] < -47'sd2147483648) o_s6[j] <= 32'sh80000000;
			else                                o_s6[j] <= sum[j][31:0];
		end
	end

	assign out_valid    = v_s6;
	assign corner_index = k_s6;
	assign corner_x     = o_s6[0];
	assign corner_y     = o_s6[1];
	assign corner_z     = o_s6[2];
	assign is_last      = (k_s6 == boc_pkg::LAST_CORNER);

endmodule
`default_nettype wire

>>> hw/rtl/boc_checker.sv
// ----------------------------------------------------------------------------
// boc_checker
// Port-level checks on the corner sequence of box_to_oriented_corners.
// ----------------------------------------------------------------------------
`default_nettype none
module boc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       out_valid,
	input wire logic [2:0] corner_index,
	input wire logic       is_last
);

	// last flag marks corner seven only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_last == (corner_index == 3'd7)))
		else $error("is_last mismatch");

	// corners of a box come in consecutive cycles
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_last) |=> (out_valid && corner_index == $past(corner_index) + 3'd1))
		else $error("corner sequence broken");

	// an accepted box later shows corner zero with out_valid
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 (out_valid && corner_index == 3'd0))
		else $error("corner zero late");

	// busy rises in the cycle after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised");

endmodule

bind box_to_oriented_corners boc_checker u_boc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.out_valid(out_valid), .corner_index(corner_index), .is_last(is_last)
);
`default_nettype wire

>>> verif/tb_box_to_oriented_corners.sv
// ----------------------------------------------------------------------------
// tb_box_to_oriented_corners
// Self-checking bench for the oriented box corner generator: boxes are sent
// in random bursts under several rotation and scale settings, and every
// corner word is compared with a fixed-point corner predictor.
// ----------------------------------------------------------------------------
module tb_box_to_oriented_corners;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]         idx;
		logic signed [31:0] x, y, z;
		logic               last;
	} corner_t;

	logic clk = 1'b0, arst_n = 1'b0, start = 1'b0;
	logic busy, cfg_ready, out_valid, is_last;
	logic signed [31:0] min_x = 0, min_y = 0, min_z = 0, max_x = 0, max_y = 0, max_z = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic [2:0] corner_index;
	logic signed [31:0] corner_x, corner_y, corner_z;

	logic signed [15:0] quat [4];
	logic signed [15:0] scl [3];
	corner_t pending_corners [$];
	int errors = 0;
	longint cycles = 0;

	box_to_oriented_corners uut (.*);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// corner prediction for one box
	task automatic predict_corners(input logic signed [31:0] lo_in [3],
			input logic signed [31:0] hi_in [3], input logic signed [31:0] pos [3]);
		longint w, x, y, z, ww, xx, yy, zz, acc, v;
		longint raw [3][3], axis [3][3], lo [3], hi [3], c [3];
		logic [2:0] s;
		corner_t e;
		w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
		ww = w*w; xx = x*x; yy = y*y; zz = z*z;
		raw[0][0] = ww+xx-yy-zz; raw[0][1] = 2*(x*y+w*z); raw[0][2] = 2*(x*z-w*y);
		raw[1][0] = 2*(x*y-w*z); raw[1][1] = ww-xx+yy-zz; raw[1][2] = 2*(y*z+w*x);
		raw[2][0] = 2*(x*z+w*y); raw[2][1] = 2*(y*z-w*x); raw[2][2] = ww-xx-yy+zz;
		for (int a = 0; a < 3; a++) begin
			for (int j = 0; j < 3; j++) axis[a][j] = rnd_shift(raw[a][j], 14);
			lo[a] = rnd_shift(longint'(lo_in[a]) * longint'(scl[a]), 8);
			hi[a] = rnd_shift(longint'(hi_in[a]) * longint'(scl[a]), 8);
		end
		for (int k = 0; k < boc_pkg::NUM_CORNERS; k++) begin
			s = boc_pkg::corner_sel(3'(k));
			for (int a = 0; a < 3; a++) c[a] = s[a] ? hi[a] : lo[a];
			e.idx = 3'(k);
			e.last = (3'(k) == boc_pkg::LAST_CORNER);
			for (int j = 0; j < 3; j++) begin
				acc = axis[0][j]*c[0] + axis[1][j]*c[1] + axis[2][j]*c[2];
				v = rnd_shift(acc, 14) + longint'(pos[j]);
				if (v > 64'sd2147483647) v = 64'sd2147483647;
				if (v < -64'sd2147483648) v = -64'sd2147483648;
				if (j == 0) e.x = 32'(v); else if (j == 1) e.y = 32'(v); else e.z = 32'(v);
			end
			pending_corners.push_back(e);
		end
	endtask

	// corner word checker
	always @(posedge clk) begin
		corner_t e;
		if (arst_n && out_valid) begin
			if (pending_corners.size() == 0) begin
				$error("corner word with none expected");
				errors++;
			end else begin
				e = pending_corners.pop_front();
				if (corner_index !== e.idx) begin
					$error("corner_index exp %0d got %0d", e.idx, corner_index); errors++;
				end
				if (corner_x !== e.x) begin
					$error("corner_x exp %0d got %0d", e.x, corner_x); errors++;
				end
				if (corner_y !== e.y) begin
					$error("corner_y exp %0d got %0d", e.y, corner_y); errors++;
				end
				if (corner_z !== e.z) begin
					$error("corner_z exp %0d got %0d", e.z, corner_z); errors++;
				end
				if (is_last !== e.last) begin
					$error("is_last exp %0d got %0d", e.last, is_last); errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_corners.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// one register write, with valid dropped again before the task returns
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == boc_pkg::REG_SCALE_X || idx == boc_pkg::REG_SCALE_Y ||
				idx == boc_pkg::REG_SCALE_Z)
			scl[idx - boc_pkg::REG_SCALE_X] = val;
		else if (idx <= boc_pkg::REG_ROT_Z)
			quat[idx] = val;
		@(posedge clk);
	endtask

	task automatic load_setting(input logic [15:0] w, x, y, z, sx, sy, sz);
		write_reg(boc_pkg::REG_ROT_W, w); write_reg(boc_pkg::REG_ROT_X, x);
		write_reg(boc_pkg::REG_ROT_Y, y); write_reg(boc_pkg::REG_ROT_Z, z);
		write_reg(boc_pkg::REG_SCALE_X, sx); write_reg(boc_pkg::REG_SCALE_Y, sy);
		write_reg(boc_pkg::REG_SCALE_Z, sz);
	endtask

	// send one box; start stays high across back-to-back words
	task automatic send_box(input logic signed [31:0] lo [3], input logic signed [31:0] hi [3],
			input logic signed [31:0] pos [3], input bit hold);
		start <= 1'b1;
		min_x <= lo[0]; min_y <= lo[1]; min_z <= lo[2];
		max_x <= hi[0]; max_y <= hi[1]; max_z <= hi[2];
		pos_x <= pos[0]; pos_y <= pos[1]; pos_z <= pos[2];
		do @(posedge clk); while (busy);
		predict_corners(lo, hi, pos);
		if (!hold) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh00800000;
		endcase
	endfunction

	task automatic send_random(input int n);
		logic signed [31:0] lo [3], hi [3], pos [3];
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			for (int a = 0; a < 3; a++) begin
				lo[a] = rand_coord(); hi[a] = rand_coord(); pos[a] = rand_coord();
			end
			if (burst == 0) begin
				burst = $urandom_range(1, 8);
				repeat ($urandom_range(0, 10)) @(posedge clk);
			end
			burst--;
			send_box(lo, hi, pos, burst != 0 && i != n - 1);
		end
	endtask

	task automatic test_directed();
		logic signed [31:0] lo [3], hi [3], pos [3];
		lo = '{32'sh10000, 32'sh20000, 32'sh30000}; hi = '{32'sh40000, 32'sh50000, 32'sh60000};
		pos = '{0, 0, 0};
		send_box(lo, hi, pos, 0);
		// min above max
		send_box(hi, lo, pos, 0);
		// extremes, saturating both ways
		lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		hi = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		send_box(lo, hi, hi, 1);
		send_box(lo, hi, lo, 1);
		send_box(hi, lo, '{-1, 0, 1}, 0);
		wait_drained();
	endtask

	task automatic test_settings();
		// quarter turn about z, then a non-unit quaternion at the register extremes
		load_setting(16'd11585, 16'd0, 16'd0, 16'd11585, 16'd512, 16'hFF00, 16'd128);
		test_directed(); send_random(30);
		wait_drained();
		load_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
		test_directed(); send_random(30);
		wait_drained();
		// out-of-range index is ignored
		write_reg(3'd7, 16'h1234);
		send_random(20);
		wait_drained();
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 6; p++) begin
			load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			send_random(25);
			wait_drained();
		end
	endtask

	initial begin
		quat = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		scl = '{16'sd256, 16'sd256, 16'sd256};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_random(20);
		wait_drained();
		test_settings();
		test_random_settings();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/boc_pkg.sv
hw/rtl/box_to_oriented_corners.sv
hw/rtl/boc_checker.sv
verif/tb_box_to_oriented_corners.sv
